/* rtl/tarc_pkg.sv */
// shared widths, event codes and register indexes of the touchpad motion converter
`default_nettype none

package tarc_pkg;

  // field widths
  localparam int unsigned TypeW   = 5;
  localparam int unsigned CodeW   = 10;
  localparam int unsigned InValW  = 16;
  localparam int unsigned OutValW = 25;
  localparam int unsigned FracW   = 8;
  localparam int unsigned SpanW   = 16;

  // stream word widths
  localparam int unsigned STdataW = 32;  // code, value, zero fill
  localparam int unsigned STuserW = TypeW;
  localparam int unsigned MTdataW = 40;  // code, value, zero fill
  localparam int unsigned MTuserW = 1 + TypeW;

  // configuration port
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = SpanW;

  localparam logic [CfgAddrW-1:0] CfgTouchpadMode = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgAxisSpan     = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgSoundDevice  = 2'd2;

  // event types
  localparam logic [TypeW-1:0] TypeSyn = 5'd0;
  localparam logic [TypeW-1:0] TypeKey = 5'd1;
  localparam logic [TypeW-1:0] TypeRel = 5'd2;
  localparam logic [TypeW-1:0] TypeAbs = 5'd3;
  localparam logic [TypeW-1:0] TypeMsc = 5'd4;

  // event codes
  localparam logic [CodeW-1:0] CodeSynReport = 10'd0;
  localparam logic [CodeW-1:0] CodeScan      = 10'd4;
  localparam logic [CodeW-1:0] CodeTouch     = 10'd330;
  localparam logic [CodeW-1:0] CodeBtnMouse  = 10'd272;
  localparam logic [CodeW-1:0] CodeBtnMouseE = 10'd276;
  localparam logic [CodeW-1:0] CodeBtnMisc   = 10'd256;
  localparam logic [CodeW-1:0] CodeBtnMiscE  = 10'd260;
  localparam logic [CodeW-1:0] CodeBtnOffset = 10'd16;

  // key values
  localparam logic [InValW-1:0] KeyRelease = 16'd0;
  localparam logic [InValW-1:0] KeyRepeat  = 16'd2;

  // span used when the configured span is zero
  localparam logic [SpanW-1:0] DefaultSpan = 16'd512;

  // packet index at which two packets have been seen
  localparam int unsigned TwoPackets = 2;

  // divider: |delta| * 32768 needs 31 bits
  localparam int unsigned ScaleShift = 15;
  localparam int unsigned NumW       = InValW + ScaleShift;
  localparam int unsigned DivCntW    = 5;
  localparam int unsigned SumW       = 32;
  localparam int unsigned FracShift  = 7;  // divide by 128

endpackage

`default_nettype wire

/* rtl/touchpad_abs_to_rel_converter.sv */
// top level of the touchpad absolute to relative motion converter
`default_nettype none

// Takes one input event word at a time and returns exactly one result word per
// event, either the event passed on (maybe translated) or a word with the drop
// flag set and all other fields zero. With touchpad_mode set, the touch key
// sets or clears a touch flag, buttons are mapped onto mouse buttons, each sync
// report while touched advances a small X/Y position history, and absolute X/Y
// positions become relative motion: (pos - pos two packets back) * 32768 / span
// plus a carried fraction, divided by 128 toward zero. Events of sound devices
// and scancode events are always dropped. An event that needs no arithmetic goes
// from acceptance to the result register through StDone, a sync that advances
// the history first copies X, then Y (the copies go through the single read
// port of the history memory), and a converted motion event goes through the
// StSub setup, the shared restoring divider that produces one quotient bit a
// cycle for 31 bits, then StFix, StAbs and StRnd. The input side is not ready
// while an event is being worked on; a finished result sits in the output
// register so the next event can be accepted while it waits. The history
// memory reads as zero after reset through per-entry valid bits, so no
// clearing pass is needed.

module touchpad_abs_to_rel_converter #(
  parameter int unsigned HISTORY_DEPTH = 4
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration write port
  input  wire logic                             cfg_we_i,
  input  wire logic [tarc_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  wire logic [tarc_pkg::CfgDataW-1:0]    cfg_wdata_i,
  // input event stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [9:0] event_code, [25:10] event_value, [31:26] zero
  input  wire logic [tarc_pkg::STdataW-1:0]     s_axis_tdata,
  // [4:0] event_type
  input  wire logic [tarc_pkg::STuserW-1:0]     s_axis_tuser,
  // result stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [9:0] out_code, [34:10] out_value, [39:35] zero
  output logic [tarc_pkg::MTdataW-1:0]          m_axis_tdata,
  // [0] drop, [5:1] out_type
  output logic [tarc_pkg::MTuserW-1:0]          m_axis_tuser
);

  localparam int unsigned IdxW     = $clog2(HISTORY_DEPTH);
  localparam int unsigned AddrW    = IdxW + 1;          // axis bit above slot index
  localparam int unsigned MemDepth = 1 << AddrW;

  localparam int unsigned TypeW   = tarc_pkg::TypeW;
  localparam int unsigned CodeW   = tarc_pkg::CodeW;
  localparam int unsigned InValW  = tarc_pkg::InValW;
  localparam int unsigned OutValW = tarc_pkg::OutValW;
  localparam int unsigned FracW   = tarc_pkg::FracW;
  localparam int unsigned SpanW   = tarc_pkg::SpanW;
  localparam int unsigned NumW    = tarc_pkg::NumW;
  localparam int unsigned SumW    = tarc_pkg::SumW;
  localparam int unsigned CntW    = tarc_pkg::DivCntW;

  // sequencer states
  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StCpX  = 4'd1;  // copy x history forward, read y
  localparam logic [3:0] StCpY  = 4'd2;  // copy y history forward
  localparam logic [3:0] StSub  = 4'd3;  // delta magnitude and sign
  localparam logic [3:0] StDiv  = 4'd4;  // one quotient bit a cycle
  localparam logic [3:0] StFix  = 4'd5;  // signed quotient plus fraction
  localparam logic [3:0] StAbs  = 4'd6;  // magnitude of the sum
  localparam logic [3:0] StRnd  = 4'd7;  // divide by 128, new fraction
  localparam logic [3:0] StDone = 4'd8;  // hand result to output register

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic             mode_q;
  logic [SpanW-1:0] span_q;
  logic             sound_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      span_q  <= '0;
      sound_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        tarc_pkg::CfgTouchpadMode: mode_q  <= cfg_wdata_i[0];
        tarc_pkg::CfgAxisSpan:     span_q  <= cfg_wdata_i[SpanW-1:0];
        tarc_pkg::CfgSoundDevice:  sound_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input word fields
  // ---------------------------------------------------------------------------
  logic [TypeW-1:0]  in_type;
  logic [CodeW-1:0]  in_code;
  logic [InValW-1:0] in_val;

  assign in_type = s_axis_tuser[TypeW-1:0];
  assign in_code = s_axis_tdata[CodeW-1:0];
  assign in_val  = s_axis_tdata[CodeW +: InValW];

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  logic [3:0]               state_q, state_d;
  logic                     touched_q;
  logic [IdxW-1:0]          pkt_idx_q;
  logic [IdxW-1:0]          prev_idx_q;
  logic                     two_seen_q;
  logic signed [FracW-1:0]  x_frac_q, y_frac_q;

  // pending result
  logic                      res_drop_q;
  logic [TypeW-1:0]          res_type_q;
  logic [CodeW-1:0]          res_code_q;
  logic signed [OutValW-1:0] res_val_q;

  // conversion datapath
  logic                      axis_q;
  logic signed [InValW-1:0]  pos_q;
  logic [SpanW-1:0]          div_q;
  logic [SpanW-1:0]          rem_q;
  logic [NumW-1:0]           quo_q;
  logic [CntW-1:0]           cnt_q;
  logic                      dneg_q;
  logic signed [SumW-1:0]    t_q;
  logic                      tneg_q;

  logic in_fire;
  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // slot arithmetic, wrapping at the history depth
  logic [IdxW-1:0] nxt_idx, back2_idx;
  assign nxt_idx   = (pkt_idx_q == IdxW'(HISTORY_DEPTH - 1)) ? '0 : pkt_idx_q + 1'b1;
  assign back2_idx = (pkt_idx_q >= IdxW'(2)) ? pkt_idx_q - IdxW'(2)
                                             : pkt_idx_q + IdxW'(HISTORY_DEPTH - 2);

  // ---------------------------------------------------------------------------
  // history memory: one write and one registered read a cycle
  // ---------------------------------------------------------------------------
  logic [InValW-1:0] hist_mem [MemDepth];
  logic [MemDepth-1:0] hist_vld_q;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr, mem_raddr;
  logic [InValW-1:0] mem_wdata;
  logic [InValW-1:0] rd_data_q;
  logic              rd_vld_q;
  logic signed [InValW-1:0] rd_val;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= hist_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (mem_we) begin
        hist_vld_q[mem_waddr] <= 1'b1;
      end
      rd_vld_q <= hist_vld_q[mem_raddr];
    end
  end

  // never-written entries read as zero
  assign rd_val = rd_vld_q ? $signed(rd_data_q) : '0;

  // ---------------------------------------------------------------------------
  // decode at acceptance
  // ---------------------------------------------------------------------------
  logic              acc_drop;
  logic [TypeW-1:0]  acc_type;
  logic [CodeW-1:0]  acc_code;
  logic              acc_touch_set, acc_touch_clr;
  logic              acc_advance;   // sync report while touched
  logic              acc_abs_store; // abs position written to history
  logic              acc_convert;   // abs position turned into motion
  logic              btn_mouse, btn_misc;

  assign btn_mouse = (in_code >= tarc_pkg::CodeBtnMouse) && (in_code <= tarc_pkg::CodeBtnMouseE);
  assign btn_misc  = (in_code >= tarc_pkg::CodeBtnMisc) && (in_code <= tarc_pkg::CodeBtnMiscE);

  always_comb begin
    acc_drop      = 1'b0;
    acc_type      = in_type;
    acc_code      = in_code;
    acc_touch_set = 1'b0;
    acc_touch_clr = 1'b0;
    acc_advance   = 1'b0;
    acc_abs_store = 1'b0;
    acc_convert   = 1'b0;
    if (mode_q) begin
      priority if (in_type == tarc_pkg::TypeKey) begin
        priority if (in_val == tarc_pkg::KeyRepeat) begin
          acc_drop = 1'b1;
        end else if (in_code == tarc_pkg::CodeTouch) begin
          acc_drop = 1'b1;
          if (in_val == tarc_pkg::KeyRelease) begin
            acc_touch_clr = 1'b1;
          end else begin
            acc_touch_set = 1'b1;
          end
        end else if (btn_misc) begin
          acc_code = in_code + tarc_pkg::CodeBtnOffset;
        end else if (!btn_mouse) begin
          acc_drop = 1'b1;
        end
      end else if (in_type == tarc_pkg::TypeSyn) begin
        acc_advance = (in_code == tarc_pkg::CodeSynReport) && touched_q;
      end else if (in_type == tarc_pkg::TypeAbs) begin
        if (!touched_q || (in_code > CodeW'(1))) begin
          acc_drop = 1'b1;
        end else begin
          acc_abs_store = 1'b1;
          if (!two_seen_q) begin
            acc_drop = 1'b1;
          end else begin
            acc_convert = 1'b1;
            acc_type    = tarc_pkg::TypeRel;
          end
        end
      end else begin
        acc_drop = 1'b1;
      end
    end
    // device and scancode filter
    if (sound_q) begin
      acc_drop = 1'b1;
    end
    if ((acc_type == tarc_pkg::TypeMsc) && (acc_code == tarc_pkg::CodeScan)) begin
      acc_drop = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // memory port control
  // ---------------------------------------------------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {1'b0, pkt_idx_q};
    mem_wdata = in_val;
    mem_raddr = {1'b0, prev_idx_q};
    unique case (state_q)
      StIdle: begin
        if (acc_advance) begin
          mem_raddr = {1'b0, pkt_idx_q};
        end else begin
          mem_raddr = {in_code[0], back2_idx};
        end
        mem_we    = in_fire && acc_abs_store;
        mem_waddr = {in_code[0], pkt_idx_q};
      end
      StCpX: begin
        mem_we    = 1'b1;
        mem_waddr = {1'b0, pkt_idx_q};
        mem_wdata = rd_val;
        mem_raddr = {1'b1, prev_idx_q};
      end
      StCpY: begin
        mem_we    = 1'b1;
        mem_waddr = {1'b1, pkt_idx_q};
        mem_wdata = rd_val;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // shared arithmetic
  // ---------------------------------------------------------------------------
  // delta magnitude: compare and pick one subtraction
  logic signed [InValW:0] pos_ext, old_ext;
  logic                   d_neg;
  logic [InValW:0]        d_mag;
  assign pos_ext = {pos_q[InValW-1], pos_q};
  assign old_ext = {rd_val[InValW-1], rd_val};
  assign d_neg   = pos_ext < old_ext;
  assign d_mag   = d_neg ? $unsigned(old_ext - pos_ext) : $unsigned(pos_ext - old_ext);

  // restoring divider step
  logic [SpanW:0] rem_sh, rem_sub;
  logic           q_bit;
  assign rem_sh  = {rem_q, quo_q[NumW-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign q_bit   = rem_sh >= {1'b0, div_q};

  // signed quotient plus carried fraction
  logic signed [SumW-1:0] q_signed, frac_ext, t_sum;
  logic signed [FracW-1:0] frac_cur;
  assign q_signed = dneg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign frac_cur = axis_q ? y_frac_q : x_frac_q;
  assign frac_ext = SumW'(frac_cur);
  assign t_sum    = q_signed + frac_ext;

  // divide by 128 toward zero, remainder keeps the sign
  logic [OutValW-1:0]      q_mag;
  logic signed [OutValW-1:0] q_out;
  logic signed [FracW-1:0] f_out;
  assign q_mag = t_q[SumW-1 -: OutValW];
  assign q_out = tneg_q ? -$signed(q_mag) : $signed(q_mag);
  assign f_out = tneg_q ? -$signed({1'b0, t_q[tarc_pkg::FracShift-1:0]})
                        : $signed({1'b0, t_q[tarc_pkg::FracShift-1:0]});

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  logic out_load;
  assign out_load = (state_q == StDone) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          priority if (acc_advance) begin
            state_d = StCpX;
          end else if (acc_convert) begin
            state_d = StSub;
          end else begin
            state_d = StDone;
          end
        end
      end
      StCpX: state_d = StCpY;
      StCpY: state_d = StDone;
      StSub: state_d = StDiv;
      StDiv: begin
        if (cnt_q == '0) begin
          state_d = StFix;
        end
      end
      StFix: state_d = StAbs;
      StAbs: state_d = StRnd;
      StRnd: state_d = StDone;
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      touched_q  <= 1'b0;
      pkt_idx_q  <= '0;
      two_seen_q <= 1'b0;
      x_frac_q   <= '0;
      y_frac_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        if (acc_touch_set) begin
          touched_q <= 1'b1;
        end
        if (acc_touch_clr) begin
          touched_q  <= 1'b0;
          pkt_idx_q  <= '0;
          two_seen_q <= 1'b0;
          x_frac_q   <= '0;
          y_frac_q   <= '0;
        end
        if (acc_advance) begin
          pkt_idx_q <= nxt_idx;
          if (nxt_idx == IdxW'(tarc_pkg::TwoPackets)) begin
            two_seen_q <= 1'b1;
          end
        end
      end
      if (state_q == StRnd) begin
        if (axis_q) begin
          y_frac_q <= f_out;
        end else begin
          x_frac_q <= f_out;
        end
      end
    end
  end

  // datapath and pending result, no reset needed
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          res_drop_q <= acc_drop;
          res_type_q <= acc_type;
          res_code_q <= acc_code;
          res_val_q  <= OutValW'($signed(in_val));
          axis_q     <= in_code[0];
          pos_q      <= $signed(in_val);
          prev_idx_q <= pkt_idx_q;
          div_q      <= (span_q == '0) ? tarc_pkg::DefaultSpan : span_q;
        end
      end
      StSub: begin
        dneg_q <= d_neg;
        quo_q  <= {d_mag[InValW-1:0], {tarc_pkg::ScaleShift{1'b0}}};
        rem_q  <= '0;
        cnt_q  <= CntW'(NumW - 1);
      end
      StDiv: begin
        rem_q <= q_bit ? rem_sub[SpanW-1:0] : rem_sh[SpanW-1:0];
        quo_q <= {quo_q[NumW-2:0], q_bit};
        cnt_q <= cnt_q - 1'b1;
      end
      StFix: t_q <= t_sum;
      StAbs: begin
        t_q    <= t_q[SumW-1] ? -t_q : t_q;
        tneg_q <= t_q[SumW-1];
      end
      StRnd: res_val_q <= q_out;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic                      out_vld_q;
  logic                      out_drop_q;
  logic [TypeW-1:0]          out_type_q;
  logic [CodeW-1:0]          out_code_q;
  logic [OutValW-1:0]        out_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  // dropped words carry zero fields
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_drop_q <= res_drop_q;
      out_type_q <= res_drop_q ? '0 : res_type_q;
      out_code_q <= res_drop_q ? '0 : res_code_q;
      out_val_q  <= res_drop_q ? '0 : res_val_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(tarc_pkg::MTdataW - CodeW - OutValW){1'b0}}, out_val_q, out_code_q};
  assign m_axis_tuser  = {out_type_q, out_drop_q};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // the two-packet flag is only ever set while a finger is down
  a_two_seen_touched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    two_seen_q |-> touched_q)
    else $error("two packets seen without touch");

  // a touch release restarts the packet count
  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && acc_touch_clr) |=> (pkt_idx_q == '0 && !two_seen_q && !touched_q))
    else $error("touch release did not restart packet count");

  // a result word only leaves when the sink took it
  a_out_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_vld_q) |-> $past(m_axis_tready))
    else $error("result word lost");

  // the divider only runs on conversions, which never start while untouched
  a_div_touched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSub) |-> (touched_q && two_seen_q))
    else $error("motion conversion without two packets");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// self-checking bench for the touchpad motion converter: directed table, then random gestures
module tb_top;
  import tarc_pkg::*;

  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned DrainCycles   = 50;   // a little over the slowest conversion
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned ItemsPerPhase = 94;
  localparam int unsigned HistDepth     = 4;

  // event codes used as stimulus data only
  localparam logic [CodeW-1:0] AbsX        = 10'd0;
  localparam logic [CodeW-1:0] AbsY        = 10'd1;
  localparam logic [CodeW-1:0] AbsPressure = 10'd24;
  localparam logic [CodeW-1:0] CodeKeyA    = 10'd30;
  localparam logic [CodeW-1:0] CodeSynMt   = 10'd2;

  typedef struct packed {
    logic [TypeW-1:0]  etype;
    logic [CodeW-1:0]  ecode;
    logic [InValW-1:0] eval;
  } ev_t;

  typedef struct packed {
    logic                      drop;
    logic [TypeW-1:0]          rtype;
    logic [CodeW-1:0]          rcode;
    logic signed [OutValW-1:0] rval;
  } res_t;

  // one line of the directed table: a register write or an event
  typedef struct packed {
    logic                is_cfg;
    logic [CfgAddrW-1:0] reg_idx;
    logic [CfgDataW-1:0] reg_val;
    ev_t                 ev;
    logic                typed;   // res holds a hand-written result
    res_t                res;
  } row_t;

  localparam res_t DropWord = '{1'b1, '0, '0, '0};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_we_i    = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i  = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [STdataW-1:0] s_axis_tdata  = '0;
  logic [STuserW-1:0] s_axis_tuser  = '0;

  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [MTdataW-1:0] m_axis_tdata;
  logic [MTuserW-1:0] m_axis_tuser;

  touchpad_abs_to_rel_converter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor copy of the registers and the block state
  logic                pad_mode;
  logic [SpanW-1:0]    span_reg;
  logic                snd_dev;
  logic                touched;
  logic [1:0]          pkt_idx;
  logic                two_seen;
  logic signed [InValW-1:0] x_hist [HistDepth];
  logic signed [InValW-1:0] y_hist [HistDepth];
  logic signed [FracW-1:0]  x_frac;
  logic signed [FracW-1:0]  y_frac;

  res_t words_due [$];      // result words still owed by the block, oldest first
  ev_t  gesture_q [$];      // random events waiting to be sent

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned cycle_count  = 0;
  int unsigned events_sent  = 0;
  int unsigned words_seen   = 0;
  int unsigned mismatches   = 0;
  int unsigned directed_cnt = 0;

  // relative motion of one axis: delta scaled by 32768/span, plus the carried
  // fraction, divided by 128 toward zero; the remainder is carried on
  function automatic logic signed [OutValW-1:0] scaled_delta(logic is_y,
      logic signed [InValW-1:0] pos, logic signed [InValW-1:0] old);
    longint span_div;
    longint acc;
    longint quo;
    span_div = (span_reg == '0) ? longint'(DefaultSpan) : longint'(span_reg);
    acc = ((longint'(pos) - longint'(old)) * 32768) / span_div;
    acc = acc + (is_y ? longint'(y_frac) : longint'(x_frac));
    quo = acc / 128;
    if (is_y) y_frac = FracW'(acc - quo * 128);
    else x_frac = FracW'(acc - quo * 128);
    return OutValW'(quo);
  endfunction

  // expected result word for one accepted event; advances the predicted state
  function automatic res_t convert_event(ev_t ev);
    logic [TypeW-1:0]          t;
    logic [CodeW-1:0]          c;
    logic signed [OutValW-1:0] v;
    logic                      dropped;
    logic [1:0]                prev;
    logic [1:0]                back2;
    res_t                      r;
    t       = ev.etype;
    c       = ev.ecode;
    v       = OutValW'(signed'(ev.eval));
    dropped = 1'b0;
    if (pad_mode) begin
      if (t == TypeKey) begin
        if (ev.eval == KeyRepeat) begin
          dropped = 1'b1;
        end else if (c == CodeTouch) begin
          // finger lifted: start over with a fresh packet count
          if (ev.eval == KeyRelease) begin
            touched  = 1'b0;
            pkt_idx  = '0;
            two_seen = 1'b0;
            x_frac   = '0;
            y_frac   = '0;
          end else begin
            touched = 1'b1;
          end
          dropped = 1'b1;
        end else if (c >= CodeBtnMouse && c <= CodeBtnMouseE) begin
          c = c;
        end else if (c >= CodeBtnMisc && c <= CodeBtnMiscE) begin
          c = c + CodeBtnOffset;
        end else begin
          dropped = 1'b1;
        end
      end else if (t == TypeSyn) begin
        // a report while touched opens the next history slot
        if (c == CodeSynReport && touched) begin
          prev    = pkt_idx;
          pkt_idx = pkt_idx + 2'd1;
          if (pkt_idx == TwoPackets) two_seen = 1'b1;
          x_hist[pkt_idx] = x_hist[prev];
          y_hist[pkt_idx] = y_hist[prev];
        end
      end else if (t == TypeAbs) begin
        if (!touched || c > AbsY) begin
          dropped = 1'b1;
        end else begin
          if (c == AbsX) x_hist[pkt_idx] = ev.eval;
          else y_hist[pkt_idx] = ev.eval;
          if (!two_seen) begin
            dropped = 1'b1;
          end else begin
            back2 = pkt_idx - 2'd2;
            if (c == AbsX) v = scaled_delta(1'b0, ev.eval, x_hist[back2]);
            else v = scaled_delta(1'b1, ev.eval, y_hist[back2]);
            t = TypeRel;
          end
        end
      end else begin
        dropped = 1'b1;
      end
    end
    if (snd_dev) dropped = 1'b1;
    if (t == TypeMsc && c == CodeScan) dropped = 1'b1;
    if (dropped) r = DropWord;
    else r = '{1'b0, t, c, v};
    return r;
  endfunction

  function automatic res_t pass_word(logic [TypeW-1:0] t, logic [CodeW-1:0] c,
      logic signed [OutValW-1:0] v);
    res_t r;
    r = '{1'b0, t, c, v};
    return r;
  endfunction

  function automatic row_t ev_row(logic [TypeW-1:0] t, logic [CodeW-1:0] c,
      logic [InValW-1:0] v);
    row_t r;
    r    = '0;
    r.ev = {t, c, v};
    return r;
  endfunction

  function automatic row_t known_row(logic [TypeW-1:0] t, logic [CodeW-1:0] c,
      logic [InValW-1:0] v, res_t w);
    row_t r;
    r       = ev_row(t, c, v);
    r.typed = 1'b1;
    r.res   = w;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
    row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  task automatic check_field(string name, logic signed [31:0] want_v,
      logic signed [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  // result side: every accepted word is held against the oldest expectation
  always @(posedge clk_i) begin : result_monitor
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.drop  = m_axis_tuser[0];
      got.rtype = m_axis_tuser[5:1];
      got.rcode = m_axis_tdata[9:0];
      got.rval  = m_axis_tdata[34:10];
      words_seen++;
      if (words_due.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got drop=%0b type=%0d code=%0d value=%0d",
                 $time, got.drop, got.rtype, got.rcode, got.rval);
        mismatches++;
      end else begin
        want = words_due.pop_front();
        check_field("drop", want.drop, got.drop);
        check_field("out_type", want.rtype, got.rtype);
        check_field("out_code", want.rcode, got.rcode);
        check_field("out_value", want.rval, got.rval);
      end
    end
  end

  // receiver back-pressure, one decision per cycle
  always @(posedge clk_i) begin
    m_axis_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
  end

  // hard stop in case the block hangs
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: no progress after %0d cycles, %0d words still due",
             $time, CycleLimit, words_due.size());
    $display("** touchpad_abs_to_rel_converter: FAILED **");
    $finish;
  end

  task automatic wait_drained();
    while (words_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CfgTouchpadMode: pad_mode = val[0];
      CfgAxisSpan:     span_reg = val;
      CfgSoundDevice:  snd_dev  = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [CfgDataW-1:0] mode, logic [CfgDataW-1:0] span,
      logic [CfgDataW-1:0] sound);
    write_reg(CfgTouchpadMode, mode);
    write_reg(CfgAxisSpan, span);
    write_reg(CfgSoundDevice, sound);
  endtask

  // drive one word, wait for the handshake, then record what must come back;
  // valid stays high so back-to-back words need no extra cycle
  task automatic send_event(ev_t ev, logic typed, res_t known);
    res_t predicted;
    if (tx_idle_pct != 0) begin
      while ($urandom_range(99) < tx_idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, ev.eval, ev.ecode};
    s_axis_tuser  <= ev.etype;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = convert_event(ev);
    words_due.push_back(typed ? known : predicted);
    events_sent++;
  endtask

  // mostly well-formed touches (press, X/Y/sync packets, release) with random
  // positions, the rest broken sequences and random noise
  task automatic build_stimulus(int unsigned n);
    int unsigned packets;
    logic signed [InValW-1:0] px;
    logic signed [InValW-1:0] py;
    while (gesture_q.size() < n) begin
      if ($urandom_range(99) < 70) begin
        gesture_q.push_back({TypeKey, CodeTouch,
                             ($urandom_range(9) == 0) ? InValW'($urandom) : 16'd1});
        px      = $urandom;
        py      = $urandom;
        packets = $urandom_range(10, 1);
        repeat (packets) begin
          if ($urandom_range(9) == 0) begin
            // finger jump across the pad
            px = $urandom;
            py = $urandom;
          end else begin
            px = px + InValW'($urandom_range(400)) - 16'd200;
            py = py + InValW'($urandom_range(400)) - 16'd200;
          end
          if ($urandom_range(9) != 0) gesture_q.push_back({TypeAbs, AbsX, px});
          if ($urandom_range(9) != 0) gesture_q.push_back({TypeAbs, AbsY, py});
          if ($urandom_range(7) == 0)
            gesture_q.push_back({TypeKey,
                                 $urandom_range(1) ? CodeBtnMouse + CodeW'($urandom_range(4))
                                                   : CodeBtnMisc + CodeW'($urandom_range(4)),
                                 InValW'($urandom_range(2))});
          gesture_q.push_back({TypeSyn, ($urandom_range(9) == 0) ? CodeSynMt : CodeSynReport,
                               16'd0});
        end
        // some touches are never released
        if ($urandom_range(4) != 0) gesture_q.push_back({TypeKey, CodeTouch, KeyRelease});
      end else begin
        case ($urandom_range(4))
          0: gesture_q.push_back({TypeW'($urandom), CodeW'($urandom), InValW'($urandom)});
          1: gesture_q.push_back({TypeKey,
                                  CodeW'($urandom_range(CodeBtnMisc, CodeBtnMouseE + 10'd2)),
                                  InValW'($urandom_range(2))});
          2: gesture_q.push_back({TypeAbs, CodeW'($urandom_range(3)), InValW'($urandom)});
          3: gesture_q.push_back({TypeSyn, CodeW'($urandom_range(3)), InValW'($urandom)});
          default:
            gesture_q.push_back({TypeMsc, $urandom_range(1) ? CodeScan : CodeW'($urandom),
                                 InValW'($urandom)});
        endcase
      end
    end
  endtask

  initial begin : stimulus
    row_t plan [$];
    pad_mode = 1'b0;
    span_reg = '0;
    snd_dev  = 1'b0;
    touched  = 1'b0;
    pkt_idx  = '0;
    two_seen = 1'b0;
    x_frac   = '0;
    y_frac   = '0;
    for (int i = 0; i < HistDepth; i++) begin
      x_hist[i] = '0;
      y_hist[i] = '0;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pass-through mode straight after reset
    plan.push_back(known_row(TypeKey, CodeKeyA, 16'd1, pass_word(TypeKey, CodeKeyA, 25'sd1)));
    plan.push_back(known_row(TypeMsc, CodeScan, 16'h7FFF, DropWord));
    plan.push_back(known_row('1, '1, 16'h8000, pass_word('1, '1, -25'sd32768)));
    plan.push_back(known_row(TypeAbs, AbsX, 16'h7FFF, pass_word(TypeAbs, AbsX, 25'sd32767)));
    // touchpad mode, default span
    plan.push_back(cfg_row(CfgTouchpadMode, 16'd1));
    plan.push_back(known_row(TypeMsc, CodeKeyA, 16'd5, DropWord));
    plan.push_back(known_row(TypeKey, CodeBtnMisc, 16'd1,
                             pass_word(TypeKey, CodeBtnMouse, 25'sd1)));
    plan.push_back(known_row(TypeKey, CodeBtnMouseE, KeyRelease,
                             pass_word(TypeKey, CodeBtnMouseE, 25'sd0)));
    plan.push_back(known_row(TypeKey, CodeBtnMouse, KeyRepeat, DropWord));
    plan.push_back(known_row(TypeKey, CodeBtnMiscE + 10'd1, 16'd1, DropWord));
    plan.push_back(known_row(TypeAbs, AbsX, 16'd100, DropWord));     // not touched yet
    plan.push_back(known_row(TypeKey, CodeTouch, 16'd1, DropWord));
    plan.push_back(known_row(TypeAbs, AbsPressure, 16'd1, DropWord));
    plan.push_back(known_row(TypeAbs, AbsX, 16'd100, DropWord));     // first packet
    plan.push_back(known_row(TypeAbs, AbsY, 16'd200, DropWord));
    plan.push_back(known_row(TypeSyn, CodeSynReport, 16'd0,
                             pass_word(TypeSyn, CodeSynReport, 25'sd0)));
    plan.push_back(known_row(TypeAbs, AbsX, 16'd110, DropWord));     // second packet
    plan.push_back(known_row(TypeSyn, CodeSynReport, 16'd0,
                             pass_word(TypeSyn, CodeSynReport, 25'sd0)));
    plan.push_back(ev_row(TypeAbs, AbsX, 16'h7FFF));                 // motion from here
    plan.push_back(ev_row(TypeAbs, AbsY, 16'h8000));
    plan.push_back(known_row(TypeSyn, CodeSynMt, 16'd7, pass_word(TypeSyn, CodeSynMt, 25'sd7)));
    plan.push_back(known_row(TypeSyn, CodeSynReport, 16'd0,
                             pass_word(TypeSyn, CodeSynReport, 25'sd0)));
    plan.push_back(ev_row(TypeAbs, AbsX, 16'd0));
    // smallest span gives the largest deltas
    plan.push_back(cfg_row(CfgAxisSpan, 16'd1));
    plan.push_back(ev_row(TypeAbs, AbsX, 16'h8000));
    plan.push_back(known_row(TypeKey, CodeTouch, KeyRelease, DropWord));
    plan.push_back(cfg_row(CfgSoundDevice, 16'd1));
    plan.push_back(known_row(TypeKey, CodeBtnMouse, 16'd1, DropWord));
    plan.push_back(cfg_row(CfgSoundDevice, 16'd0));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        s_axis_tvalid <= 1'b0;
        wait_drained();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_event(plan[i].ev, plan[i].typed, plan[i].res);
      end
    end
    directed_cnt = events_sent;

    // random phases, each with its own register settings and idle mix
    for (int p = 0; p < NumPhases; p++) begin
      s_axis_tvalid <= 1'b0;
      wait_drained();
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 47; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 47; end
        default: begin tx_idle_pct = 23; rx_stall_pct = 23; end
      endcase
      case (p)
        0: set_config(16'd1, 16'd0, 16'd0);
        1: set_config(16'd1, 16'hFFFF, 16'd0);
        2: set_config(16'd1, 16'd1, 16'd0);
        3: set_config(16'd1, CfgDataW'($urandom), 16'd0);
        4: set_config(16'd0, CfgDataW'($urandom), 16'd0);
        5: set_config(16'd1, CfgDataW'($urandom_range(2000, 1)), 16'd1);
        6: set_config(16'd1, CfgDataW'($urandom_range(4000, 100)), 16'd0);
        default: set_config(16'd1, 16'd0, 16'd0);
      endcase
      build_stimulus(ItemsPerPhase);
      while (gesture_q.size() != 0) send_event(gesture_q.pop_front(), 1'b0, DropWord);
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d events sent (%0d from the directed table), %0d result words checked, %0d mismatches",
             events_sent, directed_cnt, words_seen, mismatches);
    $display("random phases covered spans 0, 1, 65535 and random, pass-through, sound drop, idle/stall mixes");
    if (mismatches == 0 && words_due.size() == 0) begin
      $display("** touchpad_abs_to_rel_converter: PASSED **");
    end else begin
      $display("** touchpad_abs_to_rel_converter: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tarc_pkg.sv
rtl/touchpad_abs_to_rel_converter.sv
sim/tb_top.sv
